/* hw/rtl/tta_pkg.sv */
`default_nettype none

package tta_pkg;

   // Image geometry
   localparam int MaxDim    = 1024;
   localparam int TileSide  = 8;
   localparam int MaxTiles  = MaxDim / TileSide;
   localparam int PixelBits = 32;

   // Field and counter widths
   localparam int DimW     = 8;                      // width_tiles / height_tiles
   localparam int SubW     = $clog2(TileSide);       // pixel within a tile row
   localparam int PosW     = 2 * SubW;               // Morton position in a tile
   localparam int TileCntW = $clog2(MaxTiles);       // tile column / row
   localparam int PixCntW  = $clog2(MaxDim);         // pixel column / row
   localparam int SpanW    = PixCntW + 1;            // image width in pixels
   localparam int IndexW   = 20;

   // Configuration register indexes
   localparam int CsrIndexW = 2;
   localparam logic [CsrIndexW-1:0] CSR_WIDTH_TILES  = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_HEIGHT_TILES = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_DIRECTION    = 2'd2;

   localparam logic DIR_UNTILE = 1'b0;
   localparam logic DIR_TILE   = 1'b1;

   typedef struct packed {
      logic [PosW-1:0]     pos_in_tile;
      logic [TileCntW-1:0] tile_col;
      logic [TileCntW-1:0] tile_row;
      logic [PixCntW-1:0]  pixel_col;
      logic [PixCntW-1:0]  pixel_row;
   } pos_type;

   // Clamp a tile count into 1 .. MaxTiles
   function automatic logic [DimW-1:0] eff_tiles(input logic [DimW-1:0] v);
      logic [DimW-1:0] r;
      r = v;
      priority if (v == '0) begin
         r = DimW'(1);
      end else if (v > DimW'(MaxTiles)) begin
         r = DimW'(MaxTiles);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/tiled_texture_address_swizzle.sv */
// An accepted request goes to the input register, then to the result register (the
// response). Throughput: one pixel per cycle unless rsp_ready stalls; both registers
// each take one per cycle; the index math (two small multiplies) lies between them.
// Reset (synchronous, active high): both position sets go to the image origin, the
// pipeline empties, width_tiles and height_tiles go to 1 and direction to untile.
`default_nettype none

module tiled_texture_address_swizzle (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tta_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [tta_pkg::DimW-1:0]      csr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [tta_pkg::PixelBits-1:0] req_pixel,
   input  wire logic                          req_first,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [tta_pkg::PixelBits-1:0]      rsp_pixel_out,
   output logic [tta_pkg::IndexW-1:0]         rsp_dest_index,
   output logic                               rsp_last_of_image
);
   import tta_pkg::*;

   logic [DimW-1:0]      width_tiles_ff;
   logic [DimW-1:0]      height_tiles_ff;
   logic                 direction_ff;

   logic                 in_valid_ff;
   logic [PixelBits-1:0] in_pixel_ff;
   logic                 in_first_ff;

   logic                 out_valid_ff;
   logic [PixelBits-1:0] out_pixel_ff;
   logic [IndexW-1:0]    out_dest_ff;
   logic                 out_last_ff;

   logic                 advance;
   logic                 req_take;
   pos_type              pos;
   logic [IndexW-1:0]    dest_in;
   logic                 last_in;

   assign csr_ready = 1'b1;

   // Store the clamped tile counts and the direction bit
   always_ff @(posedge clock) begin
      if (reset) begin
         width_tiles_ff  <= DimW'(1);
         height_tiles_ff <= DimW'(1);
         direction_ff    <= DIR_UNTILE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH_TILES:  width_tiles_ff  <= eff_tiles(csr_data);
            CSR_HEIGHT_TILES: height_tiles_ff <= eff_tiles(csr_data);
            CSR_DIRECTION:    direction_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Advance the input stage into the result register when it has room
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pixel_ff <= req_pixel;
         in_first_ff <= req_first;
      end
   end

   tta_position u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .first        (in_first_ff),
      .width_tiles  (width_tiles_ff),
      .height_tiles (height_tiles_ff),
      .pos          (pos)
   );

   tta_index u_index (
      .pos           (pos),
      .width_tiles   (width_tiles_ff),
      .height_tiles  (height_tiles_ff),
      .direction     (direction_ff),
      .dest_index    (dest_in),
      .last_of_image (last_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pixel_ff <= in_pixel_ff;
         out_dest_ff  <= dest_in;
         out_last_ff  <= last_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_out     = out_pixel_ff;
   assign rsp_dest_index    = out_dest_ff;
   assign rsp_last_of_image = out_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/tta_position.sv */
`default_nettype none

module tta_position (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   first,
   input  wire logic [tta_pkg::DimW-1:0] width_tiles,
   input  wire logic [tta_pkg::DimW-1:0] height_tiles,
   output tta_pkg::pos_type            pos
);
   import tta_pkg::*;

   pos_type             pos_ff;
   pos_type             pos_in;
   logic [DimW-1:0]     col_inc;
   logic [DimW-1:0]     row_inc;
   logic [SpanW-1:0]    pcol_inc;
   logic [SpanW-1:0]    prow_inc;
   logic [SpanW-1:0]    wpix;
   logic [SpanW-1:0]    hpix;

   // A first transaction restarts both position sets at the origin
   assign pos = first ? '0 : pos_ff;

   assign wpix     = {width_tiles, SubW'(0)};
   assign hpix     = {height_tiles, SubW'(0)};
   assign col_inc  = DimW'(pos.tile_col) + DimW'(1);
   assign row_inc  = DimW'(pos.tile_row) + DimW'(1);
   assign pcol_inc = SpanW'(pos.pixel_col) + SpanW'(1);
   assign prow_inc = SpanW'(pos.pixel_row) + SpanW'(1);

   always_comb begin
      pos_in             = pos;
      pos_in.pos_in_tile = pos.pos_in_tile + PosW'(1);
      if (pos.pos_in_tile == '1) begin
         if (col_inc >= width_tiles) begin
            pos_in.tile_col = '0;
            if (row_inc >= height_tiles) begin
               pos_in.tile_row = '0;
            end else begin
               pos_in.tile_row = row_inc[TileCntW-1:0];
            end
         end else begin
            pos_in.tile_col = col_inc[TileCntW-1:0];
         end
      end
      if (pcol_inc >= wpix) begin
         pos_in.pixel_col = '0;
         if (prow_inc >= hpix) begin
            pos_in.pixel_row = '0;
         end else begin
            pos_in.pixel_row = prow_inc[PixCntW-1:0];
         end
      end else begin
         pos_in.pixel_col = pcol_inc[PixCntW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/tta_index.sv */
`default_nettype none

module tta_index (
   input  wire tta_pkg::pos_type         pos,
   input  wire logic [tta_pkg::DimW-1:0]   width_tiles,
   input  wire logic [tta_pkg::DimW-1:0]   height_tiles,
   input  wire logic                     direction,
   output logic [tta_pkg::IndexW-1:0]    dest_index,
   output logic                          last_of_image
);
   import tta_pkg::*;

   localparam int ProdW  = PixCntW + SpanW;
   localparam int TnumW  = TileCntW + DimW;

   logic [SpanW-1:0]    wpix;
   logic [SpanW-1:0]    hpix;
   logic [SubW-1:0]     x_sub;
   logic [SubW-1:0]     y_sub;
   logic [PixCntW-1:0]  x;
   logic [PixCntW-1:0]  y;
   logic [ProdW-1:0]    lin_index;
   logic [TnumW-1:0]    tile_num;
   logic [PosW-1:0]     morton;
   logic [TnumW+PosW-1:0] tiled_index;
   logic                last_untile;
   logic                last_tile;

   assign wpix = {width_tiles, SubW'(0)};
   assign hpix = {height_tiles, SubW'(0)};

   // Untile: even Morton bits give x, odd bits give y
   assign x_sub = {pos.pos_in_tile[4], pos.pos_in_tile[2], pos.pos_in_tile[0]};
   assign y_sub = {pos.pos_in_tile[5], pos.pos_in_tile[3], pos.pos_in_tile[1]};
   assign x     = {pos.tile_col, x_sub};
   assign y     = {pos.tile_row, y_sub};
   assign lin_index = ProdW'(y) * ProdW'(wpix) + ProdW'(x);

   // Tile: interleave the low column and row bits
   assign morton = {pos.pixel_row[2], pos.pixel_col[2],
                    pos.pixel_row[1], pos.pixel_col[1],
                    pos.pixel_row[0], pos.pixel_col[0]};
   assign tile_num = TnumW'(pos.pixel_row[PixCntW-1:SubW]) * TnumW'(width_tiles)
                   + TnumW'(pos.pixel_col[PixCntW-1:SubW]);
   assign tiled_index = {tile_num, morton};

   // Positions at or beyond the last one count as last
   assign last_untile = (pos.pos_in_tile == '1)
                      && (DimW'(pos.tile_col) >= (width_tiles - DimW'(1)))
                      && (DimW'(pos.tile_row) >= (height_tiles - DimW'(1)));
   assign last_tile   = (SpanW'(pos.pixel_col) >= (wpix - SpanW'(1)))
                      && (SpanW'(pos.pixel_row) >= (hpix - SpanW'(1)));

   always_comb begin
      unique case (direction)
         DIR_TILE: begin
            dest_index    = tiled_index[IndexW-1:0];
            last_of_image = last_tile;
         end
         default: begin
            dest_index    = lin_index[IndexW-1:0];
            last_of_image = last_untile;
         end
      endcase
   end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tta_pkg::*;

   localparam int LATENCY        = 2;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PIXELS  = 550;
   localparam logic [CsrIndexW-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [PixelBits-1:0] pixel;
      logic [IndexW-1:0]    index;
      logic                 last;
   } swizzle_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [DimW-1:0]      csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PixelBits-1:0] req_pixel = '0;
   logic                 req_first = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PixelBits-1:0] rsp_pixel_out;
   logic [IndexW-1:0]    rsp_dest_index;
   logic                 rsp_last_of_image;

   // Shadow of the register file
   logic [DimW-1:0] cfg_width  = 8'd1;
   logic [DimW-1:0] cfg_height = 8'd1;
   logic            cfg_dir    = DIR_UNTILE;

   // Position in tiled order and in raster order
   logic [PosW-1:0]     tiled_pos  = '0;
   logic [TileCntW-1:0] tiled_col  = '0;
   logic [TileCntW-1:0] tiled_row  = '0;
   logic [PixCntW-1:0]  raster_col = '0;
   logic [PixCntW-1:0]  raster_row = '0;

   swizzle_result_type pending_results[$];
   int  errors = 0;
   int  idle_cycles = 0;
   int  rsp_wait = 0;
   bit  req_steady = 1'b0;
   bit  rsp_steady = 1'b0;

   tiled_texture_address_swizzle dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_last_of_image (rsp_last_of_image)
   );

   always #2 clock = ~clock;

   function automatic int unsigned clamp_tiles(input logic [DimW-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > MaxTiles) begin
         return MaxTiles;
      end
      return v;
   endfunction

   // Tag one pixel with its destination index, then advance both position sets
   task automatic index_pixel(input logic [PixelBits-1:0] pix, input logic first,
                              output swizzle_result_type res);
      int unsigned wt, ht, wpix, hpix, x, y, dest, n;
      logic [PosW-1:0] off;
      wt   = clamp_tiles(cfg_width);
      ht   = clamp_tiles(cfg_height);
      wpix = wt * TileSide;
      hpix = ht * TileSide;
      if (first) begin
         tiled_pos  = '0;
         tiled_col  = '0;
         tiled_row  = '0;
         raster_col = '0;
         raster_row = '0;
      end
      if (cfg_dir == DIR_UNTILE) begin
         x = int'(tiled_col) * TileSide + int'({tiled_pos[4], tiled_pos[2], tiled_pos[0]});
         y = int'(tiled_row) * TileSide + int'({tiled_pos[5], tiled_pos[3], tiled_pos[1]});
         dest = y * wpix + x;
         res.last = (tiled_pos == '1) && (tiled_col >= wt - 1) && (tiled_row >= ht - 1);
      end else begin
         off = {raster_row[2], raster_col[2], raster_row[1], raster_col[1],
                raster_row[0], raster_col[0]};
         dest = ((int'(raster_row) >> 3) * wt + (int'(raster_col) >> 3)) * 64 + int'(off);
         res.last = (raster_col >= wpix - 1) && (raster_row >= hpix - 1);
      end
      res.pixel = pix;
      res.index = dest[IndexW-1:0];

      tiled_pos = tiled_pos + 1'b1;
      if (tiled_pos == '0) begin
         n = int'(tiled_col) + 1;
         if (n >= wt) begin
            tiled_col = '0;
            n = int'(tiled_row) + 1;
            tiled_row = (n >= ht) ? '0 : TileCntW'(n);
         end else begin
            tiled_col = TileCntW'(n);
         end
      end
      n = int'(raster_col) + 1;
      if (n >= wpix) begin
         raster_col = '0;
         n = int'(raster_row) + 1;
         raster_row = (n >= hpix) ? '0 : PixCntW'(n);
      end else begin
         raster_col = PixCntW'(n);
      end
   endtask

   // Send one pixel; valid is left high so that a following pixel can go back to back
   task automatic send_pixel(input logic [PixelBits-1:0] pix, input logic first);
      int gap;
      swizzle_result_type res;
      gap = req_steady ? 0 : $urandom_range(0, 4);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_first <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      index_pixel(pix, first, res);
      pending_results.push_back(res);
   endtask

   task automatic csr_write(input logic [CsrIndexW-1:0] idx, input logic [DimW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WIDTH_TILES:  cfg_width  = data;
         CSR_HEIGHT_TILES: cfg_height = data;
         CSR_DIRECTION:    cfg_dir    = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                            input logic [DimW-1:0] dir);
      csr_write(CSR_WIDTH_TILES, w);
      csr_write(CSR_HEIGHT_TILES, h);
      csr_write(CSR_DIRECTION, dir);
   endtask

   // Drain the pipeline before touching the registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'hA5A5_5A5A, 1'b0);
   endtask

   task automatic test_first_restart();
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b1);
      send_pixel($urandom, 1'b0);
   endtask

   task automatic test_dimension_clamp();
      wait_idle();
      configure(8'd0, 8'd0, {7'd0, DIR_TILE});
      send_pixel($urandom, 1'b1);
      send_pixel($urandom, 1'b0);
      wait_idle();
      configure(8'd255, 8'd200, 8'hFE);
      csr_write(CSR_UNUSED, 8'hFF);
      send_pixel($urandom, 1'b1);
      send_pixel($urandom, 1'b0);
      wait_idle();
      configure(8'd128, 8'd129, 8'hFF);
      send_pixel($urandom, 1'b1);
      send_pixel($urandom, 1'b0);
   endtask

   task automatic test_direction_switch();
      wait_idle();
      configure(8'd2, 8'd2, {7'd0, DIR_UNTILE});
      send_pixel($urandom, 1'b1);
      repeat (3) send_pixel($urandom, 1'b0);
      wait_idle();
      csr_write(CSR_DIRECTION, {7'd0, DIR_TILE});
      repeat (2) send_pixel($urandom, 1'b0);
      wait_idle();
      csr_write(CSR_DIRECTION, {7'd0, DIR_UNTILE});
      send_pixel($urandom, 1'b0);
   endtask

   function automatic logic [DimW-1:0] pick_tiles();
      logic [DimW-1:0] extremes[6] = '{8'd0, 8'd1, 8'd128, 8'd129, 8'd200, 8'd255};
      if ($urandom_range(0, 9) == 0) begin
         return extremes[$urandom_range(0, 5)];
      end
      return DimW'($urandom_range(1, 2));
   endfunction

   // Phases mostly open with a first flag, and small images are sent whole; some phases carry on mid-image
   // so that new dimensions meet counters from the old ones
   task automatic test_random_images();
      int sent, n, image, carry_on;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         wait_idle();
         configure(pick_tiles(), pick_tiles(), DimW'($urandom_range(0, 255)));
         if ($urandom_range(0, 7) == 0) begin
            csr_write(CSR_UNUSED, DimW'($urandom_range(0, 255)));
         end
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         image = clamp_tiles(cfg_width) * clamp_tiles(cfg_height) * 64;
         carry_on = ($urandom_range(0, 3) == 0);
         if (carry_on) begin
            n = $urandom_range(5, 60);
         end else if (image <= 128) begin
            n = image + $urandom_range(0, 3);
         end else begin
            n = $urandom_range(20, 100);
         end
         for (int i = 0; i < n; i++) begin
            send_pixel($urandom, (i == 0 && !carry_on) || ($urandom_range(0, 49) == 0));
            sent++;
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_first_restart();
      test_dimension_clamp();
      test_direction_switch();
      test_random_images();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Result side: stall at random, compare each transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      swizzle_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, pixel %h index %0d last %0b", $time,
                        rsp_pixel_out, rsp_dest_index, rsp_last_of_image);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_pixel_out !== want.pixel) begin
                  $display("%0t: pixel_out mismatch: expected %h, got %h", $time,
                           want.pixel, rsp_pixel_out);
                  errors++;
               end
               if (rsp_dest_index !== want.index) begin
                  $display("%0t: dest_index mismatch: expected %0d, got %0d", $time,
                           want.index, rsp_dest_index);
                  errors++;
               end
               if (rsp_last_of_image !== want.last) begin
                  $display("%0t: last_of_image mismatch: expected %0b, got %0b", $time,
                           want.last, rsp_last_of_image);
                  errors++;
               end
            end
            rsp_wait = rsp_steady ? 0 : $urandom_range(0, 4);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   // Give up once no transaction has moved on any channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
